>>> rtl/core/tsoa_pkg.sv
// Package for the two-stacks-in-one-array core: sizes, operation and status
// codes, and the controller state type.
// No dependencies.
package tsoa_pkg;

    // Store geometry
    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Operation codes
    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_DISPLAY = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DISP
    } t_state;

    // Store entry of element k of the chosen stack
    function automatic logic [ADDR_W-1:0] slot_of(input logic sel,
                                                  input logic [CNT_W-1:0] k);
        logic [CNT_W-1:0] idx;
        idx = sel ? (CNT_W'(DEPTH - 1) - k) : k;
        return idx[ADDR_W-1:0];
    endfunction

endpackage

>>> rtl/core/two_stacks_one_array_core.sv
// Top level of the two-stacks-in-one-array core: controller, counts and the
// shared single-port-read store.
// Depends on tsoa_pkg.
//
//  channel | signals                                          | direction | flow
//  --------+--------------------------------------------------+-----------+---------------
//  command | i_start, o_busy, i_operation, i_stack_select,    | in        | start & !busy
//          | i_push_value                                     |           |
//  result  | o_valid, o_status, o_data_out, o_last            | out       | o_valid strobe
//
// Push: accepted at once, result registered for the next cycle, next command at once.
// Pop: a registered store read, then registered data; busy while in S_POP. A pop
// of an empty stack gives ST_UNDERFLOW without a read. Display of n elements: one
// result per cycle, paced by the store's one read port; an empty stack gives one result.
// Reset clears both counts; store contents are not cleared. Each result is
// shown for one cycle and the receiver cannot stall it.
module two_stacks_one_array_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [1:0]                          i_operation,
    input  logic                                i_stack_select,
    input  logic signed [tsoa_pkg::DATA_W-1:0]  i_push_value,
    output logic                                o_valid,
    output logic [1:0]                          o_status,
    output logic signed [tsoa_pkg::DATA_W-1:0]  o_data_out,
    output logic                                o_last
);
    import tsoa_pkg::*;

    // Shared store
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;

    // Control state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_lower, n_lower;
    logic [CNT_W-1:0] r_upper, n_upper;
    logic             r_sel, n_sel;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_num, n_num;

    // Result register
    logic              r_valid, n_valid;
    logic [1:0]        r_status, n_status;
    logic [DATA_W-1:0] r_data, n_data;
    logic              r_last, n_last;

    logic             accept;
    logic [CNT_W-1:0] sel_cnt;
    logic [CNT_W:0]   total;
    logic             full;
    logic             disp_last;

    assign accept    = i_start && (r_state == S_IDLE);
    assign sel_cnt   = i_stack_select ? r_upper : r_lower;
    assign total     = {1'b0, r_lower} + {1'b0, r_upper};
    assign full      = total >= (CNT_W + 1)'(DEPTH);
    assign disp_last = (r_idx + CNT_W'(1)) == r_num;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_operation == OP_POP && sel_cnt != '0) begin
                    n_state = S_POP;
                end else if (accept && i_operation == OP_DISPLAY && sel_cnt != '0) begin
                    n_state = S_DISP;
                end
            end
            S_POP:   n_state = S_IDLE;
            S_DISP: begin
                if (disp_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, store access and results
    always_comb begin
        n_lower  = r_lower;
        n_upper  = r_upper;
        n_sel    = r_sel;
        n_idx    = r_idx;
        n_num    = r_num;
        n_valid  = 1'b0;
        n_status = ST_OK;
        n_data   = '0;
        n_last   = 1'b1;
        wr_en    = 1'b0;
        wr_addr  = slot_of(i_stack_select, sel_cnt);
        rd_addr  = slot_of(r_sel, r_idx + CNT_W'(1));
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_sel = i_stack_select;
                    case (i_operation)
                        OP_PUSH: begin
                            n_valid = 1'b1;
                            if (full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                wr_en = 1'b1;
                                if (i_stack_select) begin
                                    n_upper = r_upper + CNT_W'(1);
                                end else begin
                                    n_lower = r_lower + CNT_W'(1);
                                end
                            end
                        end
                        OP_POP: begin
                            if (sel_cnt == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_UNDERFLOW;
                                n_data   = '1;
                            end else begin
                                rd_addr = slot_of(i_stack_select, sel_cnt - CNT_W'(1));
                                if (i_stack_select) begin
                                    n_upper = r_upper - CNT_W'(1);
                                end else begin
                                    n_lower = r_lower - CNT_W'(1);
                                end
                            end
                        end
                        OP_DISPLAY: begin
                            if (sel_cnt == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                rd_addr = slot_of(i_stack_select, '0);
                                n_idx   = '0;
                                n_num   = sel_cnt;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                n_valid = 1'b1;
                n_data  = r_rd_data;
            end
            S_DISP: begin
                // emit element r_idx, fetch the next one
                n_valid = 1'b1;
                n_data  = r_rd_data;
                n_last  = disp_last;
                n_idx   = r_idx + CNT_W'(1);
            end
            default: ;
        endcase
    end

    // Store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_push_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lower <= '0;
            r_upper <= '0;
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_num   <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lower <= n_lower;
            r_upper <= n_upper;
            r_valid <= n_valid;
            r_idx   <= n_idx;
            r_num   <= n_num;
            r_sel   <= n_sel;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        r_last   <= n_last;
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_data_out = r_data;
    assign o_last     = r_last;

endmodule
